FILE: hdl/stereo_biquad_upmixer_core_macros.svh
// Assertion helpers used by the upmixer core RTL.
`ifndef STEREO_BIQUAD_UPMIXER_CORE_MACROS_SVH
`define STEREO_BIQUAD_UPMIXER_CORE_MACROS_SVH

// Check that is switched off while reset is high.
`define SBU_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that also holds while reset is high.
`define SBU_CHECK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/sbu_pkg.sv
`default_nettype none

package sbu_pkg;

   // Sequencer widths
   localparam int PC_W  = 6;
   localparam int SRC_W = 6;
   localparam int CF_W  = 5;
   localparam int DST_W = 4;

   localparam logic [PC_W-1:0] PC_IDLE  = 6'd0;
   localparam logic [PC_W-1:0] PC_FIRST = 6'd1;

   // Configuration registers
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_GAIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_MODE = 2'd1;
   localparam logic [15:0] GAIN_RESET = 16'd4096;
   localparam int GAIN_FRAC = 12;

   localparam logic [1:0] MODE_TWO  = 2'd0;
   localparam logic [1:0] MODE_FOUR = 2'd1;
   localparam logic [1:0] MODE_FIVE = 2'd2;

   // Coefficient table at 30 fractional bits: lowpass, hp5k, hp3k (b0 b1 b2 a1 a2),
   // then output weights 3k left, 3k right, 5k left, 5k right.
   localparam int TABLE_FRAC   = 30;
   localparam int FILTER_TAPS  = 5;
   localparam int COEF_ENTRIES = 19;
   localparam longint COEF_Q30 [COEF_ENTRIES] = '{
      64'sd313372338, 64'sd626744676, 64'sd313372338, -64'sd4480750, 64'sd184228277,
      64'sd793016690, -64'sd1586033380, 64'sd793016690, -64'sd1511297355, 64'sd586960424,
      64'sd645045546, -64'sd1290091092, 64'sd645045546, -64'sd1111506623, 64'sd394933721,
      64'sd677485290, 64'sd685330200, 64'sd339546978, 64'sd359666402
   };

   // Coefficient selector codes
   localparam logic [CF_W-1:0] CF_LP   = 5'd0;
   localparam logic [CF_W-1:0] CF_W3L  = 5'd15;
   localparam logic [CF_W-1:0] CF_W3R  = 5'd16;
   localparam logic [CF_W-1:0] CF_W5L  = 5'd17;
   localparam logic [CF_W-1:0] CF_W5R  = 5'd18;
   localparam logic [CF_W-1:0] CF_GAIN = 5'd19;

   // Operand source codes
   localparam logic [SRC_W-1:0] SRC_IN_L = 6'd0;
   localparam logic [SRC_W-1:0] SRC_IN_R = 6'd1;
   localparam logic [SRC_W-1:0] SRC_RES  = 6'd2;
   localparam logic [SRC_W-1:0] SRC_XL   = 6'd2;
   localparam logic [SRC_W-1:0] SRC_XR   = 6'd3;
   localparam logic [SRC_W-1:0] SRC_LPL  = 6'd4;
   localparam logic [SRC_W-1:0] SRC_LPR  = 6'd5;
   localparam logic [SRC_W-1:0] SRC_H5L  = 6'd6;
   localparam logic [SRC_W-1:0] SRC_H5R  = 6'd7;
   localparam logic [SRC_W-1:0] SRC_H3L  = 6'd8;
   localparam logic [SRC_W-1:0] SRC_H3R  = 6'd9;
   localparam logic [SRC_W-1:0] SRC_X1   = 6'd10;
   localparam logic [SRC_W-1:0] SRC_X2   = 6'd16;
   localparam logic [SRC_W-1:0] SRC_Y1   = 6'd22;
   localparam logic [SRC_W-1:0] SRC_Y2   = 6'd28;

   // Result destination codes; filter f writes DST_LPL + f
   localparam logic [DST_W-1:0] DST_XL  = 4'd0;
   localparam logic [DST_W-1:0] DST_XR  = 4'd1;
   localparam logic [DST_W-1:0] DST_LPL = 4'd2;
   localparam logic [DST_W-1:0] DST_H3R = 4'd7;
   localparam logic [DST_W-1:0] DST_W3L = 4'd8;
   localparam logic [DST_W-1:0] DST_W3R = 4'd9;
   localparam logic [DST_W-1:0] DST_W5L = 4'd10;
   localparam logic [DST_W-1:0] DST_W5R = 4'd11;

   // Index of each weighted path in the weight register file
   localparam logic [1:0] WI_3L = 2'd0;
   localparam logic [1:0] WI_3R = 2'd1;
   localparam logic [1:0] WI_5L = 2'd2;
   localparam logic [1:0] WI_5R = 2'd3;

   typedef enum logic [1:0] {
      BR_NEXT,
      BR_WAIT_REQ,
      BR_WAIT_OUT
   } branch_type;

   typedef enum logic {
      RND_GAIN,
      RND_COEF
   } round_kind_type;

   typedef struct packed {
      branch_type       br;
      logic [PC_W-1:0]  target;
      logic             mul;
      logic [SRC_W-1:0] src;
      logic [CF_W-1:0]  coef;
      logic             first;
      logic             neg;
      logic             last;
      round_kind_type   kind;
      logic [DST_W-1:0] dest;
      logic             upd;
      logic             load_out;
   } ucode_type;

   // Control that follows a product into the accumulate stage
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             neg;
      logic             last;
      round_kind_type   kind;
      logic [DST_W-1:0] dest;
      logic             upd;
   } tag_type;

   localparam ucode_type UC_NOP = '{
      br: BR_NEXT, target: PC_IDLE, mul: 1'b0, src: SRC_IN_L, coef: CF_LP,
      first: 1'b0, neg: 1'b0, last: 1'b0, kind: RND_COEF, dest: DST_XL,
      upd: 1'b0, load_out: 1'b0
   };

   // One multiply that forms a complete result by itself
   function automatic ucode_type uc_single(input logic [SRC_W-1:0] src,
                                           input logic [CF_W-1:0] coef,
                                           input round_kind_type kind,
                                           input logic [DST_W-1:0] dest);
      ucode_type w;
      w       = UC_NOP;
      w.mul   = 1'b1;
      w.src   = src;
      w.coef  = coef;
      w.first = 1'b1;
      w.last  = 1'b1;
      w.kind  = kind;
      w.dest  = dest;
      return w;
   endfunction

   // Tap k of biquad f; x is the filter's current input
   function automatic ucode_type uc_tap(input int f, input int k,
                                        input logic [SRC_W-1:0] x);
      ucode_type w;
      w     = UC_NOP;
      w.mul = 1'b1;
      unique case (k)
         0:       w.src = x;
         1:       w.src = SRC_W'(int'(SRC_X1) + f);
         2:       w.src = SRC_W'(int'(SRC_X2) + f);
         3:       w.src = SRC_W'(int'(SRC_Y1) + f);
         default: w.src = SRC_W'(int'(SRC_Y2) + f);
      endcase
      w.coef  = CF_W'(int'(CF_LP) + (f >> 1) * FILTER_TAPS + k);
      w.first = (k == 0);
      w.neg   = (k >= 3);
      w.last  = (k == FILTER_TAPS - 1);
      w.kind  = RND_COEF;
      w.dest  = DST_W'(int'(DST_LPL) + f);
      w.upd   = (k == FILTER_TAPS - 1);
      return w;
   endfunction

   // Control program. A result written by step t may be read from step t+2.
   function automatic ucode_type ucode(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = UC_NOP;
      unique case (pc)
         6'd0:  w.br = BR_WAIT_REQ;
         // input gain
         6'd1:  w = uc_single(SRC_IN_L, CF_GAIN, RND_GAIN, DST_XL);
         6'd2:  w = uc_single(SRC_IN_R, CF_GAIN, RND_GAIN, DST_XR);
         // left and right lowpass
         6'd3:  w = uc_tap(0, 0, SRC_XL);
         6'd4:  w = uc_tap(0, 1, SRC_XL);
         6'd5:  w = uc_tap(0, 2, SRC_XL);
         6'd6:  w = uc_tap(0, 3, SRC_XL);
         6'd7:  w = uc_tap(0, 4, SRC_XL);
         6'd8:  w = uc_tap(1, 0, SRC_XR);
         6'd9:  w = uc_tap(1, 1, SRC_XR);
         6'd10: w = uc_tap(1, 2, SRC_XR);
         6'd11: w = uc_tap(1, 3, SRC_XR);
         6'd12: w = uc_tap(1, 4, SRC_XR);
         // 5 kHz highpass
         6'd13: w = uc_tap(2, 0, SRC_XL);
         6'd14: w = uc_tap(2, 1, SRC_XL);
         6'd15: w = uc_tap(2, 2, SRC_XL);
         6'd16: w = uc_tap(2, 3, SRC_XL);
         6'd17: w = uc_tap(2, 4, SRC_XL);
         6'd18: w = uc_tap(3, 0, SRC_XR);
         6'd19: w = uc_tap(3, 1, SRC_XR);
         6'd20: w = uc_tap(3, 2, SRC_XR);
         6'd21: w = uc_tap(3, 3, SRC_XR);
         6'd22: w = uc_tap(3, 4, SRC_XR);
         // 3 kHz highpass after the lowpass
         6'd23: w = uc_tap(4, 0, SRC_LPL);
         6'd24: w = uc_tap(4, 1, SRC_LPL);
         6'd25: w = uc_tap(4, 2, SRC_LPL);
         6'd26: w = uc_tap(4, 3, SRC_LPL);
         6'd27: w = uc_tap(4, 4, SRC_LPL);
         6'd28: w = uc_tap(5, 0, SRC_LPR);
         6'd29: w = uc_tap(5, 1, SRC_LPR);
         6'd30: w = uc_tap(5, 2, SRC_LPR);
         6'd31: w = uc_tap(5, 3, SRC_LPR);
         6'd32: w = uc_tap(5, 4, SRC_LPR);
         // output weights
         6'd33: w = uc_single(SRC_H5L, CF_W5L, RND_COEF, DST_W5L);
         6'd34: w = uc_single(SRC_H5R, CF_W5R, RND_COEF, DST_W5R);
         6'd35: w = uc_single(SRC_H3L, CF_W3L, RND_COEF, DST_W3L);
         6'd36: w = uc_single(SRC_H3R, CF_W3R, RND_COEF, DST_W3R);
         6'd37: w = UC_NOP;
         // load the result register, then back to idle
         6'd38: begin
            w.load_out = 1'b1;
            w.br       = BR_WAIT_OUT;
            w.target   = PC_IDLE;
         end
         default: w = UC_NOP;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/stereo_biquad_upmixer_core.sv
// rsp_valid rises once the control program has loaded the result register.
// A pair is taken only in the idle step; the control program then runs 38 steps,
// 36 of them issuing one multiply each into the single shared MAC.
// A new pair is taken while the previous result still waits on rsp_stall.
// Reset (synchronous, active high): gain 1.0, two-channel mode, filter history zero.
`default_nettype none

`include "stereo_biquad_upmixer_core_macros.svh"

module stereo_biquad_upmixer_core #(
   parameter int SAMPLE_WIDTH   = 24,
   parameter int COEF_FRAC_BITS = 22
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input pair
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_left_sample,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_right_sample,
   // result
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_out_left_mix,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_out_right_mix,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_out_left_low,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_out_right_low,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_out_left_high,
   // configuration writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sbu_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [15:0]                           csr_data
);
   import sbu_pkg::*;

   localparam int SW    = SAMPLE_WIDTH;
   localparam int CFB   = COEF_FRAC_BITS;
   localparam int CW    = (CFB + 2 > 17) ? CFB + 2 : 17;
   localparam int PW    = SW + CW;
   localparam int AW    = PW + 3;
   localparam int SHIFT = TABLE_FRAC - CFB;
   localparam longint COEF_HALF = (64'sd1 <<< SHIFT) >>> 1;

   localparam logic signed [AW-1:0] SAT_HI  = AW'((64'sd1 <<< (SW - 1)) - 64'sd1);
   localparam logic signed [AW-1:0] SAT_LO  = ~SAT_HI;
   localparam logic signed [AW-1:0] RC_COEF = AW'(64'sd1 <<< (CFB - 1));
   localparam logic signed [AW-1:0] RC_GAIN = AW'(64'sd1 <<< (GAIN_FRAC - 1));

   // Coefficient ROM, rounded half up to CFB fractional bits; gain is Q4.12 unsigned
   function automatic logic signed [CW-1:0] coef_val(input logic [CF_W-1:0] sel,
                                                      input logic [15:0] gain);
      logic signed [63:0] r;
      if (sel == CF_GAIN) begin
         return $signed({{(CW-16){1'b0}}, gain});
      end
      r = (COEF_Q30[sel] + COEF_HALF) >>> SHIFT;
      return r[CW-1:0];
   endfunction

   function automatic logic signed [SW-1:0] sat_acc(input logic signed [AW-1:0] v);
      if (v > SAT_HI) return SAT_HI[SW-1:0];
      if (v < SAT_LO) return SAT_LO[SW-1:0];
      return v[SW-1:0];
   endfunction

   function automatic logic signed [SW-1:0] sat_sum(input logic signed [SW-1:0] a,
                                                     input logic signed [SW-1:0] b);
      logic signed [SW:0] s;
      s = {a[SW-1], a} + {b[SW-1], b};
      if (s[SW] != s[SW-1]) return s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      return s[SW-1:0];
   endfunction

   // Registers
   logic [PC_W-1:0]        pc_ff, pc_in;
   logic [15:0]            gain_ff;
   logic [1:0]             mode_ff;
   logic signed [SW-1:0]   in_ff [2];
   logic signed [SW-1:0]   res_ff [8];
   logic signed [SW-1:0]   w_ff [4];
   logic signed [SW-1:0]   x1_ff [6];
   logic signed [SW-1:0]   x2_ff [6];
   logic signed [SW-1:0]   y1_ff [6];
   logic signed [SW-1:0]   y2_ff [6];
   logic signed [SW-1:0]   xcur_ff;
   logic signed [PW-1:0]   prod_ff, prod_in;
   logic signed [AW-1:0]   acc_ff, acc_in;
   tag_type                tag_ff, tag_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]   mix_l_ff, mix_r_ff, low_l_ff, low_r_ff, high_l_ff;

   ucode_type              ctl;
   logic                   req_xfer;
   logic                   out_free;
   logic                   out_load;
   logic signed [SW-1:0]   a_val;
   logic signed [CW-1:0]   b_val;
   logic signed [AW-1:0]   acc_base, acc_add, acc_shift;
   logic signed [SW-1:0]   fin;
   logic [2:0]             filt;

   // Control word for the current step
   assign ctl       = ucode(pc_ff);
   assign req_stall = (ctl.br != BR_WAIT_REQ);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = ctl.load_out && out_free;
   assign csr_ready = 1'b1;

   // Step counter and branches
   always_comb begin
      unique case (ctl.br)
         BR_WAIT_REQ: pc_in = req_xfer ? pc_ff + PC_W'(1) : pc_ff;
         BR_WAIT_OUT: pc_in = out_free ? ctl.target : pc_ff;
         default:     pc_in = pc_ff + PC_W'(1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         mode_ff <= MODE_TWO;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INPUT_GAIN:   gain_ff <= csr_data;
            CSR_CHANNEL_MODE: mode_ff <= csr_data[1:0];
            default:          ;
         endcase
      end
   end

   // Input capture
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_ff[0] <= req_left_sample;
         in_ff[1] <= req_right_sample;
      end
   end

   // Operand A select
   always_comb begin
      priority if (ctl.src < SRC_RES) a_val = in_ff[ctl.src[0]];
      else if (ctl.src < SRC_X1) a_val = res_ff[3'(ctl.src - SRC_RES)];
      else if (ctl.src < SRC_X2) a_val = x1_ff[3'(ctl.src - SRC_X1)];
      else if (ctl.src < SRC_Y1) a_val = x2_ff[3'(ctl.src - SRC_X2)];
      else if (ctl.src < SRC_Y2) a_val = y1_ff[3'(ctl.src - SRC_Y1)];
      else                       a_val = y2_ff[3'(ctl.src - SRC_Y2)];
   end

   assign b_val   = coef_val(ctl.coef, gain_ff);
   assign prod_in = a_val * b_val;

   always_comb begin
      tag_in.valid = ctl.mul;
      tag_in.first = ctl.first;
      tag_in.neg   = ctl.neg;
      tag_in.last  = ctl.last;
      tag_in.kind  = ctl.kind;
      tag_in.dest  = ctl.dest;
      tag_in.upd   = ctl.upd;
   end

   // Multiply stage
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else begin
         tag_ff.valid <= tag_in.valid;
      end
      tag_ff.first <= tag_in.first;
      tag_ff.neg   <= tag_in.neg;
      tag_ff.last  <= tag_in.last;
      tag_ff.kind  <= tag_in.kind;
      tag_ff.dest  <= tag_in.dest;
      tag_ff.upd   <= tag_in.upd;
      prod_ff      <= prod_in;
      if (ctl.mul && ctl.first) xcur_ff <= a_val;
   end

   // Accumulate stage: the first product starts from the rounding constant
   always_comb begin
      acc_base  = tag_ff.first ? ((tag_ff.kind == RND_GAIN) ? RC_GAIN : RC_COEF) : acc_ff;
      acc_add   = {{3{prod_ff[PW-1]}}, prod_ff};
      acc_in    = tag_ff.neg ? acc_base - acc_add : acc_base + acc_add;
      acc_shift = (tag_ff.kind == RND_GAIN) ? (acc_in >>> GAIN_FRAC) : (acc_in >>> CFB);
      fin       = sat_acc(acc_shift);
      filt      = 3'(tag_ff.dest - DST_LPL);
   end

   always_ff @(posedge clock) begin
      if (tag_ff.valid) acc_ff <= acc_in;
      if (tag_ff.valid && tag_ff.last) begin
         if (tag_ff.dest < DST_W3L) res_ff[tag_ff.dest[2:0]] <= fin;
         else                       w_ff[tag_ff.dest[1:0]]   <= fin;
      end
   end

   // Filter history shifts when the filter's last tap completes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            x1_ff[i] <= '0;
            x2_ff[i] <= '0;
            y1_ff[i] <= '0;
            y2_ff[i] <= '0;
         end
      end else if (tag_ff.valid && tag_ff.last && tag_ff.upd) begin
         x2_ff[filt] <= x1_ff[filt];
         x1_ff[filt] <= xcur_ff;
         y2_ff[filt] <= y1_ff[filt];
         y1_ff[filt] <= fin;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load)        rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         mix_l_ff  <= sat_sum(w_ff[WI_3L], w_ff[WI_5L]);
         mix_r_ff  <= sat_sum(w_ff[WI_3R], w_ff[WI_5R]);
         low_l_ff  <= (mode_ff == MODE_FOUR || mode_ff == MODE_FIVE) ?
                      res_ff[3'(SRC_LPL - SRC_RES)] : '0;
         low_r_ff  <= (mode_ff == MODE_FOUR || mode_ff == MODE_FIVE) ?
                      res_ff[3'(SRC_LPR - SRC_RES)] : '0;
         high_l_ff <= (mode_ff == MODE_FIVE) ? w_ff[WI_5L] : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_left_mix  = mix_l_ff;
   assign rsp_out_right_mix = mix_r_ff;
   assign rsp_out_left_low  = low_l_ff;
   assign rsp_out_right_low = low_r_ff;
   assign rsp_out_left_high = high_l_ff;

   // Checks
   `SBU_CHECK(a_load_drained, ctl.load_out |-> !tag_ff.valid, "result loaded with MAC busy")
   `SBU_CHECK(a_rsp_from_load, $rose(rsp_valid_ff) |-> $past(out_load), "rsp_valid without load")
   `SBU_CHECK(a_start_after_xfer, req_xfer |=> (pc_ff == PC_FIRST), "program did not start")
   `SBU_CHECK(a_upd_dest, (tag_ff.valid && tag_ff.upd) |-> (tag_ff.dest >= DST_LPL &&
              tag_ff.dest <= DST_H3R), "history update with bad destination")
   `SBU_CHECK_ALWAYS(a_reset_idle, reset |=> (pc_ff == PC_IDLE && !rsp_valid_ff),
                     "not idle after reset")

endmodule

`default_nettype wire

FILE: dv/tb.sv
`default_nettype none

module tb;

   localparam int SW          = 24;
   localparam int CF_FRAC     = 22;
   localparam int IDLE_LIMIT  = 3000;
   localparam int DRAIN_WAIT  = 46;
   localparam int RAND_PHASES = 10;
   localparam int RAND_PAIRS  = 143;

   // Index of each coefficient in the Q30 table: bank * 5 + tap, then the weights
   localparam int TAPS   = 5;
   localparam int WT_3L  = 15;
   localparam int WT_3R  = 16;
   localparam int WT_5L  = 17;
   localparam int WT_5R  = 18;

   // Register index with no register behind it, and the mode code left unused
   localparam logic [sbu_pkg::CSR_IDX_W-1:0] CSR_SPARE   = 2'd2;
   localparam logic [1:0]                    MODE_UNUSED = 2'd3;

   localparam logic signed [SW-1:0] S_MAX   = 24'sh7FFFFF;
   localparam logic signed [SW-1:0] S_MIN   = 24'sh800000;
   localparam logic signed [SW-1:0] S_ZERO  = 24'sh000000;
   localparam logic signed [SW-1:0] S_ONE   = 24'sh000001;
   localparam logic signed [SW-1:0] S_NEG1  = 24'shFFFFFF;
   localparam logic signed [SW-1:0] S_ALT_A = 24'sh555555;
   localparam logic signed [SW-1:0] S_ALT_B = 24'shAAAAAA;

   typedef struct packed {
      logic [SW-1:0] left_mix;
      logic [SW-1:0] right_mix;
      logic [SW-1:0] left_low;
      logic [SW-1:0] right_low;
      logic [SW-1:0] left_high;
   } channels_type;

   typedef enum logic {
      ROW_PAIR,
      ROW_WRITE
   } row_kind_type;

   typedef struct packed {
      row_kind_type                      kind;
      logic [sbu_pkg::CSR_IDX_W-1:0]     idx;
      logic [15:0]                       data;
      logic signed [SW-1:0]              left;
      logic signed [SW-1:0]              right;
      logic                              silent;
   } row_type;

   localparam int DIR_ROWS = 27;

   // Directed rows: silent marks a row whose output is all zero by inspection
   row_type dir_table [DIR_ROWS] = '{
      '{ROW_PAIR,  sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_ZERO, S_ZERO, 1'b1},
      '{ROW_PAIR,  sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_MAX, S_MIN, 1'b0},
      '{ROW_PAIR,  sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_MIN, S_MAX, 1'b0},
      '{ROW_PAIR,  sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_ONE, S_NEG1, 1'b0},
      '{ROW_PAIR,  sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_ALT_A, S_ALT_B, 1'b0},
      '{ROW_WRITE, sbu_pkg::CSR_CHANNEL_MODE, {14'h0000, sbu_pkg::MODE_FIVE},
        S_ZERO, S_ZERO, 1'b0},
      '{ROW_PAIR,  sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_MAX, S_MAX, 1'b0},
      '{ROW_PAIR,  sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_MAX, S_MAX, 1'b0},
      '{ROW_PAIR,  sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_MIN, S_MIN, 1'b0},
      '{ROW_WRITE, sbu_pkg::CSR_INPUT_GAIN, 16'hFFFF, S_ZERO, S_ZERO, 1'b0},
      '{ROW_PAIR,  sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_MAX, S_MIN, 1'b0},
      '{ROW_PAIR,  sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_MIN, S_MAX, 1'b0},
      '{ROW_PAIR,  sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_NEG1, S_ONE, 1'b0},
      '{ROW_PAIR,  sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_ALT_B, S_ALT_A, 1'b0},
      '{ROW_WRITE, sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_ZERO, S_ZERO, 1'b0},
      '{ROW_PAIR,  sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_MAX, S_MIN, 1'b0},
      '{ROW_PAIR,  sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_MAX, S_MIN, 1'b0},
      '{ROW_WRITE, sbu_pkg::CSR_CHANNEL_MODE, {14'h3FFF, sbu_pkg::MODE_FOUR},
        S_ZERO, S_ZERO, 1'b0},
      '{ROW_WRITE, sbu_pkg::CSR_INPUT_GAIN, sbu_pkg::GAIN_RESET, S_ZERO, S_ZERO, 1'b0},
      '{ROW_PAIR,  sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_MIN, S_MIN, 1'b0},
      '{ROW_PAIR,  sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_ZERO, S_ZERO, 1'b0},
      '{ROW_WRITE, sbu_pkg::CSR_CHANNEL_MODE, {14'h0000, MODE_UNUSED},
        S_ZERO, S_ZERO, 1'b0},
      '{ROW_PAIR,  sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_MAX, S_ZERO, 1'b0},
      '{ROW_PAIR,  sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_ZERO, S_MAX, 1'b0},
      '{ROW_WRITE, CSR_SPARE, 16'hFFFF, S_ZERO, S_ZERO, 1'b0},
      '{ROW_WRITE, sbu_pkg::CSR_CHANNEL_MODE, {14'h0000, sbu_pkg::MODE_FIVE},
        S_ZERO, S_ZERO, 1'b0},
      '{ROW_PAIR,  sbu_pkg::CSR_INPUT_GAIN, 16'h0000, S_ONE, S_ONE, 1'b0}
   };

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic signed [SW-1:0]              req_left_sample = '0;
   logic signed [SW-1:0]              req_right_sample = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [SW-1:0]              rsp_out_left_mix;
   logic signed [SW-1:0]              rsp_out_right_mix;
   logic signed [SW-1:0]              rsp_out_left_low;
   logic signed [SW-1:0]              rsp_out_right_low;
   logic signed [SW-1:0]              rsp_out_left_high;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [sbu_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [15:0]                       csr_data = '0;

   stereo_biquad_upmixer_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_left_sample   (req_left_sample),
      .req_right_sample  (req_right_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_left_mix  (rsp_out_left_mix),
      .rsp_out_right_mix (rsp_out_right_mix),
      .rsp_out_left_low  (rsp_out_left_low),
      .rsp_out_right_low (rsp_out_right_low),
      .rsp_out_left_high (rsp_out_left_high),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #1 clock = ~clock;

   // Shadow copy of the filter bank: registers and per-filter history
   logic [15:0] gain_reg = sbu_pkg::GAIN_RESET;
   logic [1:0]  mode_reg = sbu_pkg::MODE_TWO;
   longint      x_past [12];
   longint      y_past [12];

   channels_type mix_due_q [$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   logic        pin_silent = 1'b0;
   logic        calm = 1'b0;
   int          stall_left = 0;

   function automatic longint sat24(input longint v);
      if (v > 64'sd8388607)
         return 64'sd8388607;
      if (v < -64'sd8388608)
         return -64'sd8388608;
      return v;
   endfunction

   // Round half up, then drop s bits (arithmetic shift floors)
   function automatic longint round_drop(input longint v, input int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   // Coefficient i, rounded from Q30 down to the block's coefficient precision
   function automatic longint coef_at(input int i);
      longint q30;
      case (i)
         0:       q30 = 64'sd313372338;
         1:       q30 = 64'sd626744676;
         2:       q30 = 64'sd313372338;
         3:       q30 = -64'sd4480750;
         4:       q30 = 64'sd184228277;
         5:       q30 = 64'sd793016690;
         6:       q30 = -64'sd1586033380;
         7:       q30 = 64'sd793016690;
         8:       q30 = -64'sd1511297355;
         9:       q30 = 64'sd586960424;
         10:      q30 = 64'sd645045546;
         11:      q30 = -64'sd1290091092;
         12:      q30 = 64'sd645045546;
         13:      q30 = -64'sd1111506623;
         14:      q30 = 64'sd394933721;
         WT_3L:   q30 = 64'sd677485290;
         WT_3R:   q30 = 64'sd685330200;
         WT_5L:   q30 = 64'sd339546978;
         default: q30 = 64'sd359666402;
      endcase
      return round_drop(q30, 30 - CF_FRAC);
   endfunction

   // One direct-form-I section; filter f uses coefficient bank f/2
   function automatic longint run_section(input int f, input longint x);
      int     base;
      longint acc;
      longint y;
      base = (f >> 1) * TAPS;
      acc  = coef_at(base) * x
           + coef_at(base + 1) * x_past[2*f]
           + coef_at(base + 2) * x_past[2*f+1]
           - coef_at(base + 3) * y_past[2*f]
           - coef_at(base + 4) * y_past[2*f+1];
      y = sat24(round_drop(acc, CF_FRAC));
      x_past[2*f+1] = x_past[2*f];
      x_past[2*f]   = x;
      y_past[2*f+1] = y_past[2*f];
      y_past[2*f]   = y;
      return y;
   endfunction

   function automatic longint weighted(input longint x, input int i);
      return sat24(round_drop(x * coef_at(i), CF_FRAC));
   endfunction

   // Expected five channels for one stereo pair; advances the shadow history
   function automatic channels_type upmix_pair(input logic signed [SW-1:0] l,
                                               input logic signed [SW-1:0] r);
      longint       xl, xr, lpl, lpr, h5l, h5r, h3l, h3r, w5l, w5r, mixl, mixr;
      channels_type o;
      logic         four, five;
      xl   = sat24(round_drop(longint'(l) * longint'(gain_reg), sbu_pkg::GAIN_FRAC));
      xr   = sat24(round_drop(longint'(r) * longint'(gain_reg), sbu_pkg::GAIN_FRAC));
      lpl  = run_section(0, xl);
      lpr  = run_section(1, xr);
      h5l  = run_section(2, xl);
      h5r  = run_section(3, xr);
      h3l  = run_section(4, lpl);
      h3r  = run_section(5, lpr);
      w5l  = weighted(h5l, WT_5L);
      w5r  = weighted(h5r, WT_5R);
      mixl = sat24(weighted(h3l, WT_3L) + w5l);
      mixr = sat24(weighted(h3r, WT_3R) + w5r);
      four = (mode_reg == sbu_pkg::MODE_FOUR) || (mode_reg == sbu_pkg::MODE_FIVE);
      five = (mode_reg == sbu_pkg::MODE_FIVE);
      o.left_mix  = mixl[SW-1:0];
      o.right_mix = mixr[SW-1:0];
      o.left_low  = four ? lpl[SW-1:0] : '0;
      o.right_low = four ? lpr[SW-1:0] : '0;
      o.left_high = five ? w5l[SW-1:0] : '0;
      return o;
   endfunction

   task automatic check_field(input string name, input logic [SW-1:0] want,
                              input logic [SW-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endtask

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 6);
      if (roll < 97)
         return $urandom_range(7, 40);
      return $urandom_range(41, 120);
   endfunction

   // Observe every transfer at the rising edge; predict, check, guard against hangs
   always @(posedge clock) begin
      channels_type fresh;
      channels_type due;
      logic         moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            if (csr_index == sbu_pkg::CSR_INPUT_GAIN)
               gain_reg = csr_data;
            else if (csr_index == sbu_pkg::CSR_CHANNEL_MODE)
               mode_reg = csr_data[1:0];
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            fresh = upmix_pair(req_left_sample, req_right_sample);
            if (pin_silent)
               fresh = '0;
            mix_due_q.push_back(fresh);
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (mix_due_q.size() == 0) begin
               $error("result transfer with no pair outstanding");
               mismatches++;
            end else begin
               due = mix_due_q.pop_front();
               check_field("out_left_mix",   due.left_mix,  rsp_out_left_mix);
               check_field("out_right_mix",  due.right_mix, rsp_out_right_mix);
               check_field("out_left_low",   due.left_low,  rsp_out_left_low);
               check_field("out_right_low",  due.right_low, rsp_out_right_low);
               check_field("out_left_high",  due.left_high, rsp_out_left_high);
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Result-side back-pressure: random stall stretches, none started in calm phases
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         stall_left <= pick_gap();
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // Offer one pair and hold it until the transfer
   task automatic send_pair(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r,
                            input logic silent);
      int gap;
      gap = calm ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      pin_silent        = silent;
      req_valid        <= 1'b1;
      req_left_sample  <= l;
      req_right_sample <= r;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   // Register write once every outstanding result has come back
   task automatic write_reg(input logic [sbu_pkg::CSR_IDX_W-1:0] idx, input logic [15:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      while (mix_due_q.size() != 0)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic signed [SW-1:0] l, r;
      logic signed [SW-1:0] drift_l, drift_r;
      logic [15:0]          gain;
      logic [1:0]           mode;
      drift_l = '0;
      drift_r = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (dir_table[i]) begin
         if (dir_table[i].kind == ROW_WRITE)
            write_reg(dir_table[i].idx, dir_table[i].data);
         else
            send_pair(dir_table[i].left, dir_table[i].right, dir_table[i].silent);
      end

      // Random phases, each under a fresh gain and channel mode
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case ($urandom_range(0, 5))
            0:       gain = 16'h0000;
            1:       gain = 16'hFFFF;
            2:       gain = sbu_pkg::GAIN_RESET;
            3:       gain = 16'($urandom_range(0, 8191));
            default: gain = 16'($urandom);
         endcase
         mode = (ph == 0) ? sbu_pkg::MODE_FIVE : 2'($urandom_range(0, 3));
         if ($urandom_range(0, 1) == 0) begin
            write_reg(sbu_pkg::CSR_INPUT_GAIN, gain);
            write_reg(sbu_pkg::CSR_CHANNEL_MODE, {14'($urandom), mode});
         end else begin
            write_reg(sbu_pkg::CSR_CHANNEL_MODE, {14'($urandom), mode});
            write_reg(sbu_pkg::CSR_INPUT_GAIN, gain);
         end
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_SPARE, 16'($urandom));
         calm = ($urandom_range(0, 3) == 0);

         for (int k = 0; k < RAND_PAIRS; k++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  l = SW'($urandom);
                  r = SW'($urandom);
               end
               4, 5: begin
                  l = SW'($urandom_range(0, 2000)) - 24'sd1000;
                  r = SW'($urandom_range(0, 2000)) - 24'sd1000;
               end
               6: begin
                  l = $urandom_range(0, 1) ? S_MAX : S_MIN;
                  r = $urandom_range(0, 1) ? S_MAX : S_MIN;
               end
               default: begin
                  // slowly moving tone, mostly inside the passbands
                  drift_l = drift_l + SW'($urandom_range(0, 40000)) - 24'sd20000;
                  drift_r = drift_r + SW'($urandom_range(0, 40000)) - 24'sd20000;
                  l = drift_l;
                  r = drift_r;
               end
            endcase
            send_pair(l, r, 1'b0);
         end
      end
      calm = 1'b0;

      // Drain, then watch for stray results
      @(negedge clock);
      req_valid <= 1'b0;
      while (mix_due_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/sbu_pkg.sv
hdl/stereo_biquad_upmixer_core.sv
dv/tb.sv
